### rtl/ksfl_pkg.sv
// Shared constants and types for the shared free-list stack block.
package ksfl_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int STACKS_DEF = 4;

    localparam int DATA_W   = 32;
    localparam int SID_W    = 2;
    localparam int STATUS_W = 2;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    // Control group for the link store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_link_ctl;

endpackage

### rtl/ksfl_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module ksfl_ram #(
    parameter int W     = ksfl_pkg::DATA_W,
    parameter int DEPTH = ksfl_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/ksfl_link.sv
// Per-slot link store; slots past the fill mark read as linked to the next slot.
module ksfl_link #(
    parameter int SLOTS = ksfl_pkg::SLOTS_DEF,
    parameter int AW    = $clog2(SLOTS),
    parameter int LW    = $clog2(SLOTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ksfl_pkg::t_link_ctl  i_ctl,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [LW-1:0]        i_wr_data,
    output logic [LW-1:0]        o_rd_data
);
    import ksfl_pkg::*;

    logic [LW-1:0] r_mem [SLOTS];
    logic [LW-1:0] r_rdata;
    logic [AW-1:0] r_rd_addr;
    logic [LW-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rdata   <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Fill mark: every slot below it has been written at least once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.wr_en && (LW'(i_wr_addr) >= r_fill)) begin
            r_fill <= LW'(i_wr_addr) + LW'(1);
        end
    end

    // An untouched slot still holds its reset link; the last one yields null.
    assign o_rd_data = (LW'(r_rd_addr) >= r_fill) ? (LW'(r_rd_addr) + LW'(1)) : r_rdata;

endmodule

### rtl/k_stacks_shared_free_list_core.sv
// Top level: several LIFO stacks sharing one slot store through a free list.
// In the accept cycle an operation issues the link memory read at the chosen slot
// (free-list head for a push, stack top for a pop), together with the data memory
// write of a push or the data memory read of a pop; then, in the execute state,
// the link is written back and the top and the free head are updated from the
// registered link read. That writeback waits while the output register holds an
// untaken result. A push with no free slot or to an out-of-range stack reports
// status full, a pop of an empty stack reports status empty; neither changes
// state. Link memory reset takes no clearing pass: a fill mark tracks which slots were ever written.
module k_stacks_shared_free_list_core #(
    parameter int SLOTS  = ksfl_pkg::SLOTS_DEF,
    parameter int STACKS = ksfl_pkg::STACKS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [ksfl_pkg::SID_W-1:0]          i_stack_id,
    input  logic signed [ksfl_pkg::DATA_W-1:0]  i_push_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ksfl_pkg::DATA_W-1:0]  o_pop_value,
    output logic [ksfl_pkg::STATUS_W-1:0]       o_status
);
    import ksfl_pkg::*;

    localparam int AW   = $clog2(SLOTS);
    localparam int LW   = $clog2(SLOTS + 1);
    localparam int REACH = 1 << SID_W;
    localparam int TOPS = (STACKS < REACH) ? STACKS : REACH;
    localparam int TIW  = (TOPS > 1) ? $clog2(TOPS) : 1;
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    t_state        r_state;
    logic [LW-1:0] r_top [TOPS];
    logic [LW-1:0] r_free_head;

    logic          r_cmd;
    logic          r_fail;
    logic [TIW-1:0] r_tidx;
    logic [LW-1:0] r_slot;
    logic [LW-1:0] r_top_old;

    logic                     r_o_valid;
    logic signed [DATA_W-1:0] r_pop_value;
    logic [STATUS_W-1:0]      r_status;

    logic          accept;
    logic          out_free;
    logic          finish;
    logic          sid_ok;
    logic [TIW-1:0] tidx;
    logic [LW-1:0] top_cur;
    logic [LW-1:0] slot;
    logic          fail;
    logic          is_pop;

    t_link_ctl     link_ctl;
    logic [AW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic [LW-1:0] link_rdata;
    logic [DATA_W-1:0] data_rdata;

    assign is_pop   = (i_cmd == CMD_POP);
    assign accept   = (r_state == ST_IDLE) && i_valid;
    assign out_free = !r_o_valid || !i_stall;
    assign finish   = (r_state == ST_EXEC) && out_free;
    assign o_stall  = (r_state != ST_IDLE);

    assign sid_ok  = (32'(i_stack_id) < STACKS);
    assign tidx    = TIW'(i_stack_id);
    assign top_cur = sid_ok ? r_top[tidx] : NIL;

    always_comb begin
        if (is_pop) begin
            slot = top_cur;
            fail = (top_cur >= NIL);
        end else begin
            slot = r_free_head;
            fail = !sid_ok || (r_free_head >= NIL);
        end
    end

    // Link writeback: a push links the slot to the old top, a pop to the free head.
    always_comb begin
        link_ctl.rd_en = accept && !fail;
        link_ctl.wr_en = finish && !r_fail;
        link_waddr     = AW'(r_slot);
        link_wdata     = (r_cmd == CMD_POP) ? r_free_head : r_top_old;
    end

    ksfl_link #(
        .SLOTS (SLOTS),
        .AW    (AW),
        .LW    (LW)
    ) u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (link_ctl),
        .i_rd_addr (AW'(slot)),
        .i_wr_addr (link_waddr),
        .i_wr_data (link_wdata),
        .o_rd_data (link_rdata)
    );

    ksfl_ram #(
        .W     (DATA_W),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_data (
        .i_clk   (i_clk),
        .i_we    (accept && !fail && !is_pop),
        .i_waddr (AW'(slot)),
        .i_wdata (i_push_value),
        .i_re    (accept && !fail && is_pop),
        .i_raddr (AW'(slot)),
        .o_rdata (data_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (i_valid) r_state <= ST_EXEC;
                ST_EXEC: if (out_free) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold the transfer's decoded fields for the writeback cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_fail    <= fail;
            r_tidx    <= tidx;
            r_slot    <= slot;
            r_top_old <= top_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            for (int i = 0; i < TOPS; i++) begin
                r_top[i] <= NIL;
            end
        end else if (finish && !r_fail) begin
            if (r_cmd == CMD_POP) begin
                r_top[r_tidx] <= link_rdata;
                r_free_head   <= r_slot;
            end else begin
                r_top[r_tidx] <= r_slot;
                r_free_head   <= link_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (finish) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (r_fail) begin
                r_pop_value <= '0;
                r_status    <= (r_cmd == CMD_POP) ? STS_EMPTY : STS_FULL;
            end else begin
                r_pop_value <= (r_cmd == CMD_POP) ? data_rdata : '0;
                r_status    <= STS_OK;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;

endmodule
